@@ hdl/efhc_pkg.sv @@
// ----------------------------------------------------------------------------
// efhc_pkg
// Shared types and constants of the Ethernet frame header classifier:
// the captured header summary, class codes, ethertypes and IP protocols.
// ----------------------------------------------------------------------------
package efhc_pkg;

	// Class codes of a result transaction; CLASS_NONE means no result.
	typedef enum logic [2:0] {
		CLASS_NONE = 3'd0,
		CLASS_ARP  = 3'd1,
		CLASS_ICMP = 3'd2,
		CLASS_TCP  = 3'd3,
		CLASS_UDP  = 3'd4,
		CLASS_DNS  = 3'd5
	} pkt_class_t;

	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ETYPE_ARP  = 16'h0806;

	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;

	localparam logic [15:0] DNS_PORT = 16'd53;

	// Smallest legal IPv4 header length in 32-bit words.
	localparam logic [3:0] IHL_MIN = 4'd5;

	// Header fields captured over one frame.
	typedef struct packed {
		logic [15:0] ether_kind;
		logic [3:0]  ip_hdr_words;
		logic [15:0] ip_total_len;
		logic [7:0]  ip_proto;
		logic [3:0]  tcp_hdr_words;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [31:0] seq;
		logic [31:0] ack;
		logic [5:0]  flags;
		logic [15:0] window;
		logic [15:0] udp_len;
		logic [15:0] arp_op;
		logic [31:0] sender_ip;
		logic [31:0] target_ip;
		logic [47:0] sender_mac;
	} hdr_sum_t;

	// IPv4 header length with short values raised to the minimum.
	function automatic logic [3:0] ihl_eff(input logic [3:0] ihl);
		return (ihl < IHL_MIN) ? IHL_MIN : ihl;
	endfunction

endpackage

@@ hdl/efhc_capture.sv @@
// ----------------------------------------------------------------------------
// efhc_capture
// Byte counter and header field capture. Each accepted byte updates the
// captured fields; the last byte of a frame moves the completed summary
// into the _s1 register and clears the capture state.
// ----------------------------------------------------------------------------
module efhc_capture #(
	parameter int L2_HEADER_BYTES = 14
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0]              frame_byte,
	input  logic                    last_byte,
	output logic                    sum_valid,
	input  logic                    sum_ready,
	output efhc_pkg::hdr_sum_t      sum
);

	localparam logic [15:0] L2_LEN   = 16'(L2_HEADER_BYTES);
	localparam logic [15:0] ETYPE_HI = 16'(L2_HEADER_BYTES - 2);
	localparam logic [15:0] ETYPE_LO = 16'(L2_HEADER_BYTES - 1);

	logic [15:0]        byte_idx_q;
	efhc_pkg::hdr_sum_t cap_q;
	efhc_pkg::hdr_sum_t cap_nxt;
	efhc_pkg::hdr_sum_t sum_s1;
	logic               sum_valid_s1;
	logic               accept;
	logic [15:0]        rel;
	logic [5:0]         l4_base;
	logic [15:0]        l4_diff;
	logic [3:0]         q;

	// Take a byte when the summary stage is free or drains this cycle
	assign in_ready  = !sum_valid_s1 || sum_ready;
	assign accept    = in_valid && in_ready;
	assign sum_valid = sum_valid_s1;
	assign sum       = sum_s1;

	// Place the current byte into the header fields
	always_comb begin
		cap_nxt = cap_q;
		rel     = byte_idx_q - L2_LEN;
		l4_base = {efhc_pkg::ihl_eff(cap_q.ip_hdr_words), 2'b00};
		l4_diff = rel - {10'd0, l4_base};
		q       = l4_diff[3:0];

		if (byte_idx_q == ETYPE_HI) begin
			cap_nxt.ether_kind[15:8] = frame_byte;
		end
		if (byte_idx_q == ETYPE_LO) begin
			cap_nxt.ether_kind[7:0] = frame_byte;
		end

		if (byte_idx_q >= L2_LEN) begin
			// ARP body
			if (rel == 16'd6) begin
				cap_nxt.arp_op[15:8] = frame_byte;
			end
			if (rel == 16'd7) begin
				cap_nxt.arp_op[7:0] = frame_byte;
			end
			if (rel >= 16'd8 && rel < 16'd14) begin
				cap_nxt.sender_mac[8*(13 - rel[3:0]) +: 8] = frame_byte;
			end
			if (rel >= 16'd14 && rel < 16'd18) begin
				cap_nxt.sender_ip[8*(17 - rel[4:0]) +: 8] = frame_byte;
			end
			if (rel >= 16'd24 && rel < 16'd28) begin
				cap_nxt.target_ip[8*(27 - rel[4:0]) +: 8] = frame_byte;
			end

			// IPv4 header
			if (rel == 16'd0) begin
				cap_nxt.ip_hdr_words = frame_byte[3:0];
			end
			if (rel == 16'd2) begin
				cap_nxt.ip_total_len[15:8] = frame_byte;
			end
			if (rel == 16'd3) begin
				cap_nxt.ip_total_len[7:0] = frame_byte;
			end
			if (rel == 16'd9) begin
				cap_nxt.ip_proto = frame_byte;
			end

			// TCP or UDP header, located after the IPv4 header
			if (rel >= {10'd0, l4_base} && l4_diff < 16'd16) begin
				if (q < 4'd2) begin
					cap_nxt.src_port[8*(1 - q) +: 8] = frame_byte;
				end else if (q < 4'd4) begin
					cap_nxt.dst_port[8*(3 - q) +: 8] = frame_byte;
				end else if (q < 4'd8) begin
					cap_nxt.seq[8*(7 - q) +: 8] = frame_byte;
				end else if (q < 4'd12) begin
					cap_nxt.ack[8*(11 - q) +: 8] = frame_byte;
				end else if (q == 4'd12) begin
					cap_nxt.tcp_hdr_words = frame_byte[7:4];
				end else if (q == 4'd13) begin
					cap_nxt.flags = frame_byte[5:0];
				end else begin
					cap_nxt.window[8*(15 - q) +: 8] = frame_byte;
				end
				if (q == 4'd4 || q == 4'd5) begin
					cap_nxt.udp_len[8*(5 - q) +: 8] = frame_byte;
				end
			end
		end
	end

	// Advance the capture state; clear it at the end of each frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q <= '0;
			cap_q      <= '0;
		end else if (accept) begin
			if (last_byte) begin
				byte_idx_q <= '0;
				cap_q      <= '0;
			end else begin
				cap_q <= cap_nxt;
				if (byte_idx_q != 16'hFFFF) begin
					byte_idx_q <= byte_idx_q + 16'd1;
				end
			end
		end
	end

	// Hold the finished summary until the result stage takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_valid_s1 <= 1'b0;
		end else if (accept && last_byte) begin
			sum_valid_s1 <= 1'b1;
		end else if (sum_ready) begin
			sum_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_byte) begin
			sum_s1 <= cap_nxt;
		end
	end

endmodule

@@ hdl/efhc_result.sv @@
// ----------------------------------------------------------------------------
// efhc_result
// Classifies a finished frame summary, selects the fields that belong to
// its class and holds them in the output register until taken. Frames of
// no known class are dropped here.
// ----------------------------------------------------------------------------
module efhc_result (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sum_valid,
	output logic               sum_ready,
	input  efhc_pkg::hdr_sum_t sum,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         pkt_class,
	output logic [15:0]        src_port,
	output logic [15:0]        dst_port,
	output logic [5:0]         tcp_flag_bits,
	output logic [31:0]        seq_number,
	output logic [31:0]        ack_number,
	output logic [15:0]        window_size,
	output logic [15:0]        length_value,
	output logic [15:0]        arp_opcode,
	output logic [31:0]        sender_ipv4,
	output logic [31:0]        target_ipv4,
	output logic [47:0]        sender_hw_addr
);

	efhc_pkg::pkt_class_t cls;
	logic                 out_valid_q;
	logic                 advance;
	logic                 load;
	logic [6:0]           tcp_hdr_len;
	logic [15:0]          tcp_len;

	logic [2:0]  class_q;
	logic [15:0] src_q;
	logic [15:0] dst_q;
	logic [5:0]  flags_q;
	logic [31:0] seq_q;
	logic [31:0] ack_q;
	logic [15:0] window_q;
	logic [15:0] len_q;
	logic [15:0] arp_op_q;
	logic [31:0] sip_q;
	logic [31:0] tip_q;
	logic [47:0] smac_q;

	// Decide the class from ethertype, protocol and ports
	always_comb begin
		cls = efhc_pkg::CLASS_NONE;
		if (sum.ether_kind == efhc_pkg::ETYPE_ARP) begin
			cls = efhc_pkg::CLASS_ARP;
		end else if (sum.ether_kind == efhc_pkg::ETYPE_IPV4) begin
			case (sum.ip_proto)
				efhc_pkg::PROTO_ICMP: cls = efhc_pkg::CLASS_ICMP;
				efhc_pkg::PROTO_TCP:  cls = efhc_pkg::CLASS_TCP;
				efhc_pkg::PROTO_UDP: begin
					if (sum.src_port == efhc_pkg::DNS_PORT ||
					    sum.dst_port == efhc_pkg::DNS_PORT) begin
						cls = efhc_pkg::CLASS_DNS;
					end else begin
						cls = efhc_pkg::CLASS_UDP;
					end
				end
				default: cls = efhc_pkg::CLASS_NONE;
			endcase
		end
	end

	// TCP payload length, floored at zero
	always_comb begin
		tcp_hdr_len = {1'b0, efhc_pkg::ihl_eff(sum.ip_hdr_words), 2'b00}
		            + {1'b0, sum.tcp_hdr_words, 2'b00};
		if (sum.ip_total_len > {9'd0, tcp_hdr_len}) begin
			tcp_len = sum.ip_total_len - {9'd0, tcp_hdr_len};
		end else begin
			tcp_len = '0;
		end
	end

	// Drop unknown frames at once; others wait for the output register
	assign advance   = !out_valid_q || out_ready;
	assign sum_ready = (cls == efhc_pkg::CLASS_NONE) || advance;
	assign load      = sum_valid && (cls != efhc_pkg::CLASS_NONE) && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the fields of the class, zero for the rest
	always_ff @(posedge clk) begin
		if (load) begin
			class_q  <= cls;
			src_q    <= '0;
			dst_q    <= '0;
			flags_q  <= '0;
			seq_q    <= '0;
			ack_q    <= '0;
			window_q <= '0;
			len_q    <= '0;
			arp_op_q <= '0;
			sip_q    <= '0;
			tip_q    <= '0;
			smac_q   <= '0;
			case (cls)
				efhc_pkg::CLASS_ARP: begin
					arp_op_q <= sum.arp_op;
					sip_q    <= sum.sender_ip;
					tip_q    <= sum.target_ip;
					smac_q   <= sum.sender_mac;
				end
				efhc_pkg::CLASS_TCP: begin
					src_q    <= sum.src_port;
					dst_q    <= sum.dst_port;
					flags_q  <= sum.flags;
					seq_q    <= sum.seq;
					ack_q    <= sum.ack;
					window_q <= sum.window;
					len_q    <= tcp_len;
				end
				efhc_pkg::CLASS_UDP, efhc_pkg::CLASS_DNS: begin
					src_q <= sum.src_port;
					dst_q <= sum.dst_port;
					len_q <= sum.udp_len;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign pkt_class      = class_q;
	assign src_port       = src_q;
	assign dst_port       = dst_q;
	assign tcp_flag_bits  = flags_q;
	assign seq_number     = seq_q;
	assign ack_number     = ack_q;
	assign window_size    = window_q;
	assign length_value   = len_q;
	assign arp_opcode     = arp_op_q;
	assign sender_ipv4    = sip_q;
	assign target_ipv4    = tip_q;
	assign sender_hw_addr = smac_q;

endmodule

@@ hdl/ethernet_frame_header_classifier.sv @@
// ----------------------------------------------------------------------------
// ethernet_frame_header_classifier
// Takes an Ethernet frame one byte per transaction and reports one
// classification (ARP, ICMP, TCP, UDP, DNS) with its header fields per frame of a known class.
// ----------------------------------------------------------------------------
// The block accepts one frame byte every clock cycle while in_ready is high,
// with no gap between frames. Each byte updates a saturating byte counter
// and the header field captures; the L4 header is found from the IPv4
// header length. The last byte of a frame moves the captured summary into a
// register, from which it is classified into the output register once that
// register is free. Frames of other types give no result. in_ready drops
// only while a result waits for out_ready and the summary of a further
// frame of a known class is already queued behind it.
module ethernet_frame_header_classifier #(
	parameter int L2_HEADER_BYTES = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  frame_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  pkt_class,
	output logic [15:0] src_port,
	output logic [15:0] dst_port,
	output logic [5:0]  tcp_flag_bits,
	output logic [31:0] seq_number,
	output logic [31:0] ack_number,
	output logic [15:0] window_size,
	output logic [15:0] length_value,
	output logic [15:0] arp_opcode,
	output logic [31:0] sender_ipv4,
	output logic [31:0] target_ipv4,
	output logic [47:0] sender_hw_addr
);

	logic               sum_valid;
	logic               sum_ready;
	efhc_pkg::hdr_sum_t sum;

	// Byte counting and field capture
	efhc_capture #(
		.L2_HEADER_BYTES(L2_HEADER_BYTES)
	) u_capture (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.frame_byte (frame_byte),
		.last_byte  (last_byte),
		.sum_valid  (sum_valid),
		.sum_ready  (sum_ready),
		.sum        (sum)
	);

	// Classification and output register
	efhc_result u_result (
		.clk            (clk),
		.arst_n         (arst_n),
		.sum_valid      (sum_valid),
		.sum_ready      (sum_ready),
		.sum            (sum),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pkt_class      (pkt_class),
		.src_port       (src_port),
		.dst_port       (dst_port),
		.tcp_flag_bits  (tcp_flag_bits),
		.seq_number     (seq_number),
		.ack_number     (ack_number),
		.window_size    (window_size),
		.length_value   (length_value),
		.arp_opcode     (arp_opcode),
		.sender_ipv4    (sender_ipv4),
		.target_ipv4    (target_ipv4),
		.sender_hw_addr (sender_hw_addr)
	);

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Ethernet frame header classifier. Frames of
// every class, plus unknown types, short and malformed frames, are
// streamed in one byte per transaction. A byte-level predictor builds the
// expected classification of each frame, and every result transaction is
// checked field by field. Both sides idle at random, and the receiver
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int L2_BYTES    = 14;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_WAIT  = 20;
	localparam int HOLD_CYCLES = 400;

	typedef enum {
		FR_ARP, FR_ICMP, FR_TCP, FR_UDP, FR_DNS, FR_ETYPE_OTHER, FR_PROTO_OTHER, FR_NOISE
	} frame_kind_t;

	typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} link_byte_t;

	typedef struct packed {
		efhc_pkg::pkt_class_t cls;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [5:0]  flags;
		logic [31:0] seq;
		logic [31:0] ack;
		logic [15:0] win;
		logic [15:0] len;
		logic [15:0] op;
		logic [31:0] sip;
		logic [31:0] tip;
		logic [47:0] smac;
	} frame_report_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic [7:0]  frame_byte = 8'd0;
	logic        last_byte = 1'b0;
	logic        out_ready = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic [2:0]  pkt_class;
	logic [15:0] src_port;
	logic [15:0] dst_port;
	logic [5:0]  tcp_flag_bits;
	logic [31:0] seq_number;
	logic [31:0] ack_number;
	logic [15:0] window_size;
	logic [15:0] length_value;
	logic [15:0] arp_opcode;
	logic [31:0] sender_ipv4;
	logic [31:0] target_ipv4;
	logic [47:0] sender_hw_addr;

	// Stimulus and expected results
	link_byte_t    link_q[$];
	logic [7:0]    frame_buf[$];
	frame_report_t report_q[$];
	link_byte_t    next_byte;

	int fail_count     = 0;
	int cycle_count    = 0;
	int frames_sent    = 0;
	int accepted_bytes = 0;
	int total_bytes    = 0;
	int phase_bound1   = 0;
	int phase_bound2   = 0;
	int hold_frame     = -1;
	int hold_left      = 0;
	bit hold_done      = 1'b0;

	// Predictor state: header fields captured so far in the current frame
	logic [15:0] byte_pos   = '0;
	logic [15:0] got_etype  = '0;
	logic [3:0]  got_ihl    = '0;
	logic [15:0] got_iplen  = '0;
	logic [7:0]  got_proto  = '0;
	logic [3:0]  got_doff   = '0;
	logic [15:0] got_sport  = '0;
	logic [15:0] got_dport  = '0;
	logic [31:0] got_seq    = '0;
	logic [31:0] got_ack    = '0;
	logic [5:0]  got_flags  = '0;
	logic [15:0] got_win    = '0;
	logic [15:0] got_udplen = '0;
	logic [15:0] got_op     = '0;
	logic [31:0] got_sip    = '0;
	logic [31:0] got_tip    = '0;
	logic [47:0] got_smac   = '0;

	ethernet_frame_header_classifier #(
		.L2_HEADER_BYTES(L2_BYTES)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.frame_byte    (frame_byte),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pkt_class     (pkt_class),
		.src_port      (src_port),
		.dst_port      (dst_port),
		.tcp_flag_bits (tcp_flag_bits),
		.seq_number    (seq_number),
		.ack_number    (ack_number),
		.window_size   (window_size),
		.length_value  (length_value),
		.arp_opcode    (arp_opcode),
		.sender_ipv4   (sender_ipv4),
		.target_ipv4   (target_ipv4),
		.sender_hw_addr(sender_hw_addr)
	);

	// Clock: 2 ns period
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Hold reset low at the start, then release it once
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Advance one byte of the frame through the predictor; on the last byte
	// classify the frame, queue its report and clear the captures.
	function automatic void classify_byte(input logic [7:0] b, input logic lst);
		int                   r;
		int                   q;
		logic [3:0]           ihl;
		logic [15:0]          hdr_len;
		frame_report_t        rep;
		efhc_pkg::pkt_class_t cls;

		r = int'(byte_pos) - L2_BYTES;
		if (byte_pos == L2_BYTES - 2) got_etype[15:8] = b;
		if (byte_pos == L2_BYTES - 1) got_etype[7:0] = b;
		if (r >= 0) begin
			// ARP body
			if (r == 6) got_op[15:8] = b;
			if (r == 7) got_op[7:0] = b;
			if (r >= 8 && r < 14) got_smac[8 * (13 - r) +: 8] = b;
			if (r >= 14 && r < 18) got_sip[8 * (17 - r) +: 8] = b;
			if (r >= 24 && r < 28) got_tip[8 * (27 - r) +: 8] = b;
			// IPv4 header
			if (r == 0) got_ihl = b[3:0];
			if (r == 2) got_iplen[15:8] = b;
			if (r == 3) got_iplen[7:0] = b;
			if (r == 9) got_proto = b;
			// L4 header, located by the header length with short values raised
			ihl = (got_ihl < efhc_pkg::IHL_MIN) ? efhc_pkg::IHL_MIN : got_ihl;
			q = r - 4 * int'(ihl);
			if (q >= 0 && q < 16) begin
				if (q < 2) got_sport[8 * (1 - q) +: 8] = b;
				else if (q < 4) got_dport[8 * (3 - q) +: 8] = b;
				else if (q < 8) got_seq[8 * (7 - q) +: 8] = b;
				else if (q < 12) got_ack[8 * (11 - q) +: 8] = b;
				else if (q == 12) got_doff = b[7:4];
				else if (q == 13) got_flags = b[5:0];
				else got_win[8 * (15 - q) +: 8] = b;
				if (q == 4 || q == 5) got_udplen[8 * (5 - q) +: 8] = b;
			end
		end
		if (byte_pos != 16'hFFFF) byte_pos = byte_pos + 16'd1;

		if (lst) begin
			cls = efhc_pkg::CLASS_NONE;
			if (got_etype == efhc_pkg::ETYPE_ARP) begin
				cls = efhc_pkg::CLASS_ARP;
			end else if (got_etype == efhc_pkg::ETYPE_IPV4) begin
				if (got_proto == efhc_pkg::PROTO_ICMP) cls = efhc_pkg::CLASS_ICMP;
				else if (got_proto == efhc_pkg::PROTO_TCP) cls = efhc_pkg::CLASS_TCP;
				else if (got_proto == efhc_pkg::PROTO_UDP)
					cls = (got_sport == efhc_pkg::DNS_PORT ||
						got_dport == efhc_pkg::DNS_PORT) ?
						efhc_pkg::CLASS_DNS : efhc_pkg::CLASS_UDP;
			end
			rep = '0;
			rep.cls = cls;
			case (cls)
				efhc_pkg::CLASS_ARP: begin
					rep.op   = got_op;
					rep.sip  = got_sip;
					rep.tip  = got_tip;
					rep.smac = got_smac;
				end
				efhc_pkg::CLASS_TCP: begin
					ihl = (got_ihl < efhc_pkg::IHL_MIN) ? efhc_pkg::IHL_MIN : got_ihl;
					hdr_len = 16'(4 * int'(ihl) + 4 * int'(got_doff));
					rep.sport = got_sport;
					rep.dport = got_dport;
					rep.flags = got_flags;
					rep.seq   = got_seq;
					rep.ack   = got_ack;
					rep.win   = got_win;
					rep.len   = (got_iplen > hdr_len) ? got_iplen - hdr_len : 16'd0;
				end
				efhc_pkg::CLASS_UDP, efhc_pkg::CLASS_DNS: begin
					rep.sport = got_sport;
					rep.dport = got_dport;
					rep.len   = got_udplen;
				end
				default: ;
			endcase
			if (cls != efhc_pkg::CLASS_NONE) report_q.push_back(rep);
			// Clear every capture for the next frame
			byte_pos   = '0;
			got_etype  = '0;
			got_ihl    = '0;
			got_iplen  = '0;
			got_proto  = '0;
			got_doff   = '0;
			got_sport  = '0;
			got_dport  = '0;
			got_seq    = '0;
			got_ack    = '0;
			got_flags  = '0;
			got_win    = '0;
			got_udplen = '0;
			got_op     = '0;
			got_sip    = '0;
			got_tip    = '0;
			got_smac   = '0;
		end
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// Compare one result transaction with the oldest expected report
	function automatic void check_report();
		frame_report_t rep;

		if (report_q.size() == 0) begin
			$display("%0t: unexpected result, class %0d", $time, pkt_class);
			fail_count++;
		end else begin
			rep = report_q.pop_front();
			check_field("pkt_class", rep.cls, pkt_class);
			check_field("src_port", rep.sport, src_port);
			check_field("dst_port", rep.dport, dst_port);
			check_field("tcp_flag_bits", rep.flags, tcp_flag_bits);
			check_field("seq_number", rep.seq, seq_number);
			check_field("ack_number", rep.ack, ack_number);
			check_field("window_size", rep.win, window_size);
			check_field("length_value", rep.len, length_value);
			check_field("arp_opcode", rep.op, arp_opcode);
			check_field("sender_ipv4", rep.sip, sender_ipv4);
			check_field("target_ipv4", rep.tip, target_ipv4);
			check_field("sender_hw_addr", rep.smac, sender_hw_addr);
		end
	endfunction

	function automatic logic [7:0] fill_byte(input fill_t fill);
		if (fill == FILL_ZERO) return 8'h00;
		if (fill == FILL_ONES) return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// Write an n-byte big-endian field into the frame; bytes past a cut are dropped
	function automatic void poke(input int off, input logic [63:0] v, input int n);
		int k;

		for (k = 0; k < n; k++)
			if (off + k >= 0 && off + k < frame_buf.size())
				frame_buf[off + k] = v[8 * (n - 1 - k) +: 8];
	endfunction

	// Build one frame of the given kind and queue its bytes. A negative ihl or
	// sel picks one at random; cut truncates the frame; extra appends bytes.
	// Returns 1 for a complete frame of a class that gives a result.
	function automatic bit build_frame(input frame_kind_t kind, input fill_t fill, input int ihl,
		input int cut, input int sel, input int extra);
		int          hdr;
		int          l4;
		int          full;
		int          len;
		int          k;
		int          tot;
		logic [15:0] et;
		logic [15:0] sp;
		logic [15:0] dp;
		logic [7:0]  pr;
		logic [7:0]  tmp;

		if (ihl < 0) begin
			k = $urandom_range(0, 19);
			ihl = (k < 15) ? 5 : (k < 18) ? $urandom_range(6, 15) : $urandom_range(0, 4);
		end
		hdr = 4 * ((ihl < 5) ? 5 : ihl);
		l4 = L2_BYTES + hdr;
		case (kind)
			FR_ARP:         full = L2_BYTES + 28;
			FR_TCP:         full = l4 + 20;
			FR_ETYPE_OTHER: full = L2_BYTES + $urandom_range(0, 40);
			FR_NOISE:       full = $urandom_range(1, 70);
			default:        full = l4 + 8;
		endcase
		if (fill == FILL_RANDOM) full += $urandom_range(0, 6);
		full += extra;
		len = (cut > 0 && cut < full) ? cut : full;
		frame_buf.delete();
		for (k = 0; k < len; k++) frame_buf.push_back(fill_byte(fill));

		if (kind == FR_ARP) begin
			poke(L2_BYTES - 2, efhc_pkg::ETYPE_ARP, 2);
			// mostly request or reply opcodes
			if (fill == FILL_RANDOM && $urandom_range(0, 3) != 0)
				poke(L2_BYTES + 6, $urandom_range(1, 2), 2);
		end else if (kind == FR_ETYPE_OTHER) begin
			if (fill == FILL_ZERO) et = 16'h0000;
			else if (fill == FILL_ONES) et = 16'hFFFF;
			else begin
				case ($urandom_range(0, 3))
					0:       et = 16'h86DD;
					1:       et = 16'h0801;
					2:       et = 16'h0807;
					default: et = 16'($urandom_range(0, 65535));
				endcase
			end
			if (et == efhc_pkg::ETYPE_IPV4 || et == efhc_pkg::ETYPE_ARP) et = 16'h8100;
			poke(L2_BYTES - 2, et, 2);
		end else if (kind != FR_NOISE) begin
			poke(L2_BYTES - 2, efhc_pkg::ETYPE_IPV4, 2);
			if (len > L2_BYTES) begin
				tmp = frame_buf[L2_BYTES];
				frame_buf[L2_BYTES] = {tmp[7:4], ihl[3:0]};
			end
			case (kind)
				FR_ICMP: pr = efhc_pkg::PROTO_ICMP;
				FR_TCP:  pr = efhc_pkg::PROTO_TCP;
				FR_UDP, FR_DNS: pr = efhc_pkg::PROTO_UDP;
				default: begin
					pr = fill_byte(fill);
					if (pr == efhc_pkg::PROTO_ICMP || pr == efhc_pkg::PROTO_TCP ||
						pr == efhc_pkg::PROTO_UDP) pr = pr + 8'd1;
				end
			endcase
			poke(L2_BYTES + 9, pr, 1);

			// Mostly consistent lengths, some arbitrary, some shorter than the headers
			if (fill == FILL_RANDOM) begin
				k = $urandom_range(0, 19);
				tot = (k < 14) ? len - L2_BYTES :
					(k < 17) ? $urandom_range(0, 65535) : $urandom_range(0, hdr + 24);
				poke(L2_BYTES + 2, tot, 2);
				if (kind == FR_TCP && $urandom_range(0, 3) != 0 && len > l4 + 12) begin
					tmp = frame_buf[l4 + 12];
					frame_buf[l4 + 12] = {4'd5, tmp[3:0]};
				end
				if ((kind == FR_UDP || kind == FR_DNS) && k < 14) poke(l4 + 4, len - l4, 2);
			end

			if (kind == FR_UDP || kind == FR_DNS) begin
				sp = {fill_byte(fill), fill_byte(fill)};
				dp = {fill_byte(fill), fill_byte(fill)};
				if (kind == FR_UDP) begin
					if (sp == efhc_pkg::DNS_PORT) sp = sp + 16'd1;
					if (dp == efhc_pkg::DNS_PORT) dp = dp - 16'd1;
				end else begin
					k = (sel < 0) ? $urandom_range(0, 2) : sel;
					if (k != 1) sp = efhc_pkg::DNS_PORT;
					if (k != 0) dp = efhc_pkg::DNS_PORT;
				end
				poke(l4, sp, 2);
				poke(l4 + 2, dp, 2);
			end
		end

		for (k = 0; k < len; k++) link_q.push_back('{frame_buf[k], k == len - 1});
		return kind != FR_ETYPE_OTHER && kind != FR_PROTO_OTHER && kind != FR_NOISE
			&& len == full;
	endfunction

	// Idle percentages: sender light and receiver heavy, then swapped, then none
	function automatic int tx_idle_pct();
		if (frames_sent < phase_bound1) return 11;
		if (frames_sent < phase_bound2) return 73;
		return 0;
	endfunction

	function automatic int rx_idle_pct();
		if (frames_sent < phase_bound1) return 73;
		if (frames_sent < phase_bound2) return 11;
		return 0;
	endfunction

	// Driver: offer the next byte once the current transaction is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_ready) begin
				if (link_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct()) begin
					next_byte = link_q.pop_front();
					in_valid   <= 1'b1;
					frame_byte <= next_byte.data;
					last_byte  <= next_byte.last;
					if (next_byte.last) frames_sent <= frames_sent + 1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off to back the block up
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (!hold_done && frames_sent == hold_frame) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= rx_idle_pct());
			end
		end
	end

	// Monitor: predict from accepted bytes, check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				classify_byte(frame_byte, last_byte);
				accepted_bytes <= accepted_bytes + 1;
			end
			if (out_valid && out_ready) check_report();
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		frame_kind_t kind;
		fill_t       fill;
		int          k;
		int          n0;
		int          rand_bytes;
		int          n_frames;

		// Field extremes for ARP, ICMP, TCP and UDP frames
		void'(build_frame(FR_ARP, FILL_RANDOM, -1, 0, -1, 0));
		void'(build_frame(FR_ARP, FILL_ZERO, 5, 0, -1, 0));
		void'(build_frame(FR_ARP, FILL_ONES, 5, 0, -1, 0));
		void'(build_frame(FR_ICMP, FILL_RANDOM, 5, 0, -1, 0));
		void'(build_frame(FR_ICMP, FILL_ONES, 15, 0, -1, 0));
		void'(build_frame(FR_TCP, FILL_RANDOM, 5, 0, -1, 0));
		void'(build_frame(FR_TCP, FILL_ONES, 15, 0, -1, 0));
		void'(build_frame(FR_TCP, FILL_ZERO, 0, 0, -1, 0));
		void'(build_frame(FR_UDP, FILL_RANDOM, 5, 0, -1, 0));
		void'(build_frame(FR_UDP, FILL_ONES, 15, 0, -1, 0));
		void'(build_frame(FR_UDP, FILL_ZERO, 5, 0, -1, 0));
		// DNS port at the source, at the destination, at both
		void'(build_frame(FR_DNS, FILL_RANDOM, 5, 0, 0, 0));
		void'(build_frame(FR_DNS, FILL_RANDOM, 5, 0, 1, 0));
		void'(build_frame(FR_DNS, FILL_RANDOM, 6, 0, 2, 0));
		// Malformed header lengths below the minimum
		void'(build_frame(FR_TCP, FILL_RANDOM, 4, 0, -1, 0));
		void'(build_frame(FR_UDP, FILL_RANDOM, 1, 0, -1, 0));
		// Unknown ethertypes and IP protocols
		void'(build_frame(FR_ETYPE_OTHER, FILL_RANDOM, 5, 0, -1, 0));
		void'(build_frame(FR_ETYPE_OTHER, FILL_ONES, 5, 0, -1, 0));
		void'(build_frame(FR_PROTO_OTHER, FILL_RANDOM, 5, 0, -1, 0));
		void'(build_frame(FR_PROTO_OTHER, FILL_ZERO, 5, 0, -1, 0));
		// Short frames: missing bytes read as zero
		void'(build_frame(FR_TCP, FILL_RANDOM, 5, 1, -1, 0));
		void'(build_frame(FR_TCP, FILL_RANDOM, 5, 13, -1, 0));
		void'(build_frame(FR_ICMP, FILL_RANDOM, 5, 14, -1, 0));
		void'(build_frame(FR_ARP, FILL_RANDOM, 5, 35, -1, 0));
		void'(build_frame(FR_UDP, FILL_RANDOM, 5, 36, -1, 0));

		// Random frames, mostly well formed with random content
		rand_bytes = 0;
		while (rand_bytes < 800) begin
			k = $urandom_range(0, 99);
			if (k < 15) kind = FR_ARP;
			else if (k < 25) kind = FR_ICMP;
			else if (k < 55) kind = FR_TCP;
			else if (k < 68) kind = FR_UDP;
			else if (k < 78) kind = FR_DNS;
			else if (k < 85) kind = FR_ETYPE_OTHER;
			else if (k < 90) kind = FR_PROTO_OTHER;
			else kind = FR_NOISE;
			k = $urandom_range(0, 19);
			fill = (k == 0) ? FILL_ZERO : (k == 1) ? FILL_ONES : FILL_RANDOM;
			n0 = link_q.size();
			void'(build_frame(kind, fill, -1,
				($urandom_range(0, 9) == 0) ? $urandom_range(1, 90) : 0, -1, 0));
			rand_bytes += link_q.size() - n0;
		end

		// Split the run into the three idling phases; hold off in the last
		n_frames = 0;
		foreach (link_q[k]) if (link_q[k].last) n_frames++;
		total_bytes = link_q.size();
		phase_bound1 = n_frames / 3;
		phase_bound2 = 2 * n_frames / 3;
		hold_frame = phase_bound2 + 3;

		// Drain: every byte taken and every report matched
		@(posedge clk);
		while (accepted_bytes != total_bytes || report_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
